// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the tracker.
// Depends on nothing; take it in by `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, clocked on the rising edge, off during reset.
`define KCTV_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// A valid that is not taken must stay high in the next cycle.
`define KCTV_HOLD(lbl, ck, rn, vld, rdy, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) vld && !rdy |=> vld) else $error(msg);

`endif

// ----- rtl/core/kctv_pkg.sv -----
// Package of the constant-velocity tracker: widths, reset values, codes and
// saturation helpers. Depends on nothing.
package kctv_pkg;

    localparam int POS_W     = 32;
    localparam int COV_W     = 48;
    localparam int NOISE_W   = 32;
    localparam int GAIN_FRAC = 32;
    localparam int GAIN_W    = GAIN_FRAC + 1;
    localparam int CFG_IDX_W = 2;

    localparam logic [NOISE_W-1:0] PROCESS_NOISE_RST    = 32'd1678;
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST    = 32'd1677722;
    localparam logic [NOISE_W-1:0] START_COVARIANCE_RST = 32'd1677722;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COVARIANCE = 2'd2;

    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_START  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_PPS,
        ST_SUMS,
        ST_DIV0,
        ST_WDIV0,
        ST_WDIV1,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_COMB,
        ST_APPLY,
        ST_OUT
    } kctv_state_t;

    // Products of one axis, in the order they are worked
    typedef enum logic [2:0] {
        MOP_POS,
        MOP_VEL,
        MOP_PP,
        MOP_PV,
        MOP_VV
    } kctv_mop_t;

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [POS_W+1:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W+1:POS_W-1] == 3'b000 || v[POS_W+1:POS_W-1] == 3'b111)
            r = v[POS_W-1:0];
        else if (v[POS_W+1])
            r = {1'b1, {(POS_W-1){1'b0}}};
        else
            r = {1'b0, {(POS_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic [COV_W-1:0] sat_cov(input logic [COV_W+2:0] v);
        logic [COV_W-1:0] r;
        if (|v[COV_W+2:COV_W])
            r = '1;
        else
            r = v[COV_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/kctv_div.sv -----
// Restoring divider for the Kalman gains: floor(num * 2^32 / den), clamped.
// Depends on kctv_pkg.
module kctv_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [kctv_pkg::COV_W-1:0]    num,
    input  logic [kctv_pkg::COV_W:0]      den,
    output logic                          done,
    output logic [kctv_pkg::GAIN_W-1:0]   quot
);

    localparam int QB    = kctv_pkg::GAIN_FRAC;
    localparam int CNT_W = $clog2(QB);
    localparam int DW    = kctv_pkg::COV_W + 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic [QB-1:0]    q_reg;
    logic [QB:0]      quot_reg;

    logic [DW:0]      shifted;
    logic             take;
    logic [DW:0]      diff;
    logic [DW-1:0]    rem_next;
    logic             zero_den;
    logic             full_gain;

    assign shifted   = {rem_reg, 1'b0};
    assign take      = shifted >= {1'b0, den_reg};
    assign diff      = shifted - {1'b0, den_reg};
    assign rem_next  = take ? diff[DW-1:0] : shifted[DW-1:0];
    assign zero_den  = (den == '0);
    assign full_gain = ({1'b0, num} >= den);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                if (zero_den || full_gain)
                    done_reg <= 1'b1;
                else
                begin
                    busy_reg <= 1'b1;
                    cnt_reg  <= CNT_W'(QB - 1);
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {1'b0, num};
            den_reg <= den;
            q_reg   <= '0;
            if (zero_den)
                quot_reg <= '0;
            else if (full_gain)
                quot_reg <= {1'b1, {QB{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[QB-2:0], take};
            if (cnt_reg == '0)
                quot_reg <= {1'b0, q_reg[QB-2:0], take};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ----- rtl/core/kalman_tracker_const_velocity_2d_top.sv -----
// Constant-velocity Kalman tracker on two axes, Q16.16 positions, Q24.24 covariances.
// A start word goes straight to the result stage; an update word works each axis in turn
// through predict, two divisions and five products, each product 2 passes of the shared
// 48x16 multiplier. One word at a time; the next word is taken in the cycle after the
// result loads, later while the previous result still waits for the receiver.
// Reset (rst_n, asynchronous, active low): registers to defaults, zero track, pp = vv = 0.1.
module kalman_tracker_const_velocity_2d_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  action,
    input  logic signed [kctv_pkg::POS_W-1:0]     meas_x,
    input  logic signed [kctv_pkg::POS_W-1:0]     meas_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [kctv_pkg::POS_W-1:0]     est_x,
    output logic signed [kctv_pkg::POS_W-1:0]     est_y,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [kctv_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [kctv_pkg::NOISE_W-1:0]          cfg_data
);

    localparam int PW = kctv_pkg::POS_W;
    localparam int CW = kctv_pkg::COV_W;
    localparam int NW = kctv_pkg::NOISE_W;
    localparam int GW = kctv_pkg::GAIN_W;

    kctv_pkg::kctv_state_t state_reg, state_next;
    kctv_pkg::kctv_mop_t   op_reg, op_next;

    logic          axis_reg;
    logic          out_valid_reg;
    logic [NW-1:0] q_noise_reg, r_noise_reg, start_cov_reg;

    // Track state, one entry per axis (x then y)
    logic signed [PW-1:0] pos_reg [2];
    logic signed [PW-1:0] vel_reg [2];
    logic [CW-1:0]        c0_reg  [2];
    logic [CW-1:0]        c1_reg  [2];
    logic [CW-1:0]        c2_reg  [2];

    // Working registers of the current axis
    logic signed [PW-1:0] zx_reg, zy_reg;
    logic signed [PW-1:0] pred_reg;
    logic                 eneg_reg;
    logic [PW-1:0]        emag_reg;
    logic [CW+1:0]        acca_reg;
    logic [CW:0]          accb_reg;
    logic [CW-1:0]        pp_reg, pv_reg, vv_reg;
    logic [CW:0]          s_reg;
    logic [GW-1:0]        k0_reg, k1_reg;
    logic [63:0]          lo_reg, hi_reg;
    logic [CW:0]          rr_reg;
    logic signed [PW-1:0] est_x_reg, est_y_reg;

    logic                 in_acc;
    logic signed [PW-1:0] cur_p, cur_v, cur_z;
    logic [CW-1:0]        cur_c0, cur_c1, cur_c2;
    logic signed [PW:0]   pv_sum;
    logic [CW+1:0]        acca_c;
    logic [CW:0]          accb_c;
    logic [CW:0]          pvraw_c;
    logic signed [PW:0]   e_c;
    logic [PW:0]          emag_c;
    logic [GW-1:0]        comp;
    logic [CW-1:0]        mul_a;
    logic [GW-1:0]        mul_k;
    logic [15:0]          mul_b;
    logic [63:0]          mul_prod;
    logic [64:0]          cr_sum, mg_sum;
    logic [CW:0]          rr_c;
    logic signed [PW+1:0] corr_base, corr_d, corr_sum;
    logic                 div_start;
    logic [CW-1:0]        div_num;
    logic                 div_done;
    logic [GW-1:0]        div_quot;
    logic                 out_load;

    assign in_ready  = (state_reg == kctv_pkg::ST_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == kctv_pkg::ST_OUT) && (!out_valid_reg || out_ready);

    // Operands of the axis in hand
    assign cur_p  = pos_reg[axis_reg];
    assign cur_v  = vel_reg[axis_reg];
    assign cur_c0 = c0_reg[axis_reg];
    assign cur_c1 = c1_reg[axis_reg];
    assign cur_c2 = c2_reg[axis_reg];
    assign cur_z  = axis_reg ? zy_reg : zx_reg;

    // Predict: position plus velocity, covariance grown by process noise
    assign pv_sum  = {cur_p[PW-1], cur_p} + {cur_v[PW-1], cur_v};
    assign acca_c  = {2'b00, cur_c0} + {1'b0, cur_c1, 1'b0};
    assign accb_c  = {1'b0, cur_c2} + {{(CW+1-NW){1'b0}}, q_noise_reg};
    assign pvraw_c = {1'b0, cur_c1} + {1'b0, cur_c2};

    // Innovation against the registered prediction
    assign e_c    = {cur_z[PW-1], cur_z} - {pred_reg[PW-1], pred_reg};
    assign emag_c = e_c[PW] ? (PW+1)'(-e_c) : e_c;

    assign comp = {1'b1, {(GW-1){1'b0}}} - k0_reg;

    // Shared divider, gain k0 then k1
    assign div_start = (state_reg == kctv_pkg::ST_DIV0) ||
                       ((state_reg == kctv_pkg::ST_WDIV0) && div_done);
    assign div_num   = (state_reg == kctv_pkg::ST_DIV0) ? pp_reg : pv_reg;

    kctv_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Shared multiplier: operand pair chosen by the product in hand
    always_comb
    begin
        case (op_reg)
            kctv_pkg::MOP_POS:
            begin
                mul_a = {{(CW-PW){1'b0}}, emag_reg};
                mul_k = k0_reg;
            end
            kctv_pkg::MOP_VEL:
            begin
                mul_a = {{(CW-PW){1'b0}}, emag_reg};
                mul_k = k1_reg;
            end
            kctv_pkg::MOP_PP:
            begin
                mul_a = pp_reg;
                mul_k = comp;
            end
            kctv_pkg::MOP_PV:
            begin
                mul_a = pv_reg;
                mul_k = comp;
            end
            default:
            begin
                mul_a = pv_reg;
                mul_k = k1_reg;
            end
        endcase
    end

    assign mul_b    = (state_reg == kctv_pkg::ST_MUL_LO) ? mul_k[15:0] : mul_k[31:16];
    assign mul_prod = {16'b0, mul_a} * {48'b0, mul_b};

    // Correction product rounds the full product; covariance product keeps the split
    // rounding of the high and low halves
    assign cr_sum = {1'b0, hi_reg[47:0], 16'b0} + {1'b0, lo_reg} + 65'h8000_0000;
    assign mg_sum = {1'b0, hi_reg} + {17'b0, lo_reg[63:16]} + 65'h8000;

    always_comb
    begin
        if (mul_k[GW-1])
            rr_c = {1'b0, mul_a};
        else if (op_reg == kctv_pkg::MOP_POS || op_reg == kctv_pkg::MOP_VEL)
            rr_c = {16'b0, cr_sum[64:32]};
        else
            rr_c = mg_sum[64:16];
    end

    assign corr_base = (op_reg == kctv_pkg::MOP_POS) ? {{2{pred_reg[PW-1]}}, pred_reg}
                                                     : {{2{cur_v[PW-1]}}, cur_v};
    assign corr_d    = {1'b0, rr_reg[PW:0]};
    assign corr_sum  = eneg_reg ? corr_base - corr_d : corr_base + corr_d;

    always_comb
    begin
        case (op_reg)
            kctv_pkg::MOP_POS: op_next = kctv_pkg::MOP_VEL;
            kctv_pkg::MOP_VEL: op_next = kctv_pkg::MOP_PP;
            kctv_pkg::MOP_PP:  op_next = kctv_pkg::MOP_PV;
            kctv_pkg::MOP_PV:  op_next = kctv_pkg::MOP_VV;
            default:           op_next = kctv_pkg::MOP_POS;
        endcase
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kctv_pkg::ST_IDLE:
                if (in_acc)
                    state_next = (action == kctv_pkg::ACT_START) ? kctv_pkg::ST_OUT
                                                                 : kctv_pkg::ST_PRED;
            kctv_pkg::ST_PRED:   state_next = kctv_pkg::ST_PPS;
            kctv_pkg::ST_PPS:    state_next = kctv_pkg::ST_SUMS;
            kctv_pkg::ST_SUMS:   state_next = kctv_pkg::ST_DIV0;
            kctv_pkg::ST_DIV0:   state_next = kctv_pkg::ST_WDIV0;
            kctv_pkg::ST_WDIV0:
                if (div_done)
                    state_next = kctv_pkg::ST_WDIV1;
            kctv_pkg::ST_WDIV1:
                if (div_done)
                    state_next = kctv_pkg::ST_MUL_LO;
            kctv_pkg::ST_MUL_LO: state_next = kctv_pkg::ST_MUL_HI;
            kctv_pkg::ST_MUL_HI: state_next = kctv_pkg::ST_COMB;
            kctv_pkg::ST_COMB:   state_next = kctv_pkg::ST_APPLY;
            kctv_pkg::ST_APPLY:
                if (op_reg != kctv_pkg::MOP_VV)
                    state_next = kctv_pkg::ST_MUL_LO;
                else if (!axis_reg)
                    state_next = kctv_pkg::ST_PRED;
                else
                    state_next = kctv_pkg::ST_OUT;
            kctv_pkg::ST_OUT:
                if (out_load)
                    state_next = kctv_pkg::ST_IDLE;
            default:             state_next = kctv_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= kctv_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Control, configuration and track state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg      <= 1'b0;
            op_reg        <= kctv_pkg::MOP_POS;
            out_valid_reg <= 1'b0;
            q_noise_reg   <= kctv_pkg::PROCESS_NOISE_RST;
            r_noise_reg   <= kctv_pkg::MEASURE_NOISE_RST;
            start_cov_reg <= kctv_pkg::START_COVARIANCE_RST;
            for (int i = 0; i < 2; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                c0_reg[i]  <= CW'(kctv_pkg::START_COVARIANCE_RST);
                c1_reg[i]  <= '0;
                c2_reg[i]  <= CW'(kctv_pkg::START_COVARIANCE_RST);
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    kctv_pkg::CFG_PROCESS_NOISE:    q_noise_reg   <= cfg_data;
                    kctv_pkg::CFG_MEASURE_NOISE:    r_noise_reg   <= cfg_data;
                    kctv_pkg::CFG_START_COVARIANCE: start_cov_reg <= cfg_data;
                    default:                        ;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (in_acc)
            begin
                axis_reg <= 1'b0;
                op_reg   <= kctv_pkg::MOP_POS;
                if (action == kctv_pkg::ACT_START)
                begin
                    // Start a track: position as given, still, diagonal covariance
                    pos_reg[0] <= meas_x;
                    pos_reg[1] <= meas_y;
                    for (int i = 0; i < 2; i++)
                    begin
                        vel_reg[i] <= '0;
                        c0_reg[i]  <= {{(CW-NW){1'b0}}, start_cov_reg};
                        c1_reg[i]  <= '0;
                        c2_reg[i]  <= {{(CW-NW){1'b0}}, start_cov_reg};
                    end
                end
            end

            if (state_reg == kctv_pkg::ST_APPLY)
            begin
                op_reg <= op_next;
                case (op_reg)
                    kctv_pkg::MOP_POS: pos_reg[axis_reg] <= kctv_pkg::sat32(corr_sum);
                    kctv_pkg::MOP_VEL: vel_reg[axis_reg] <= kctv_pkg::sat32(corr_sum);
                    kctv_pkg::MOP_PP:  c0_reg[axis_reg]  <= rr_reg[CW-1:0];
                    kctv_pkg::MOP_PV:  c1_reg[axis_reg]  <= rr_reg[CW-1:0];
                    default:
                    begin
                        // Hold vv at zero rather than let rounding take it negative
                        if ({1'b0, vv_reg} >= rr_reg)
                            c2_reg[axis_reg] <= vv_reg - rr_reg[CW-1:0];
                        else
                            c2_reg[axis_reg] <= '0;
                        axis_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    // Working datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            zx_reg <= meas_x;
            zy_reg <= meas_y;
        end
        case (state_reg)
            kctv_pkg::ST_PRED:
            begin
                pred_reg <= kctv_pkg::sat32({pv_sum[PW], pv_sum});
                acca_reg <= acca_c;
                accb_reg <= accb_c;
                pv_reg   <= kctv_pkg::sat_cov({2'b00, pvraw_c});
                vv_reg   <= kctv_pkg::sat_cov({2'b00, accb_c});
            end
            kctv_pkg::ST_PPS:
            begin
                pp_reg   <= kctv_pkg::sat_cov({1'b0, acca_reg} + {2'b00, accb_reg});
                eneg_reg <= e_c[PW];
                emag_reg <= emag_c[PW-1:0];
            end
            kctv_pkg::ST_SUMS:
                s_reg <= {1'b0, pp_reg} + {{(CW+1-NW){1'b0}}, r_noise_reg};
            kctv_pkg::ST_WDIV0:
                if (div_done)
                    k0_reg <= div_quot;
            kctv_pkg::ST_WDIV1:
                if (div_done)
                    k1_reg <= div_quot;
            kctv_pkg::ST_MUL_LO: lo_reg <= mul_prod;
            kctv_pkg::ST_MUL_HI: hi_reg <= mul_prod;
            kctv_pkg::ST_COMB:   rr_reg <= rr_c;
            default:             ;
        endcase
        if (out_load)
        begin
            est_x_reg <= pos_reg[0];
            est_y_reg <= pos_reg[1];
        end
    end

    assign out_valid = out_valid_reg;
    assign est_x     = est_x_reg;
    assign est_y     = est_y_reg;

endmodule

// ----- rtl/core/kctv_chk.sv -----
// Port checker for the tracker top level, bound to it below.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module kctv_chk (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready
);

    `KCTV_HOLD(a_out_hold, clk, rst_n, out_valid, out_ready, "result word dropped before taken")
    `KCTV_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready while busy")
    `KCTV_ASSERT(a_no_instant_result, clk, rst_n, in_valid && in_ready |=> !$rose(out_valid), "result too early")
    `KCTV_ASSERT(a_ready_with_result, clk, rst_n, $rose(out_valid) |-> in_ready, "not ready after result")

endmodule

bind kalman_tracker_const_velocity_2d_top kctv_chk u_kctv_chk (.*);

// ----- sim/tb.sv -----
// Testbench of the two-axis constant-velocity tracker: drives measurement and start words,
// predicts each corrected position in bit-true fixed point and checks every result word.
// Depends on kctv_pkg and kalman_tracker_const_velocity_2d_top.
`timescale 1ns / 1ps

module tb;

    localparam logic [63:0] COV_SAT  = 64'hFFFF_FFFF_FFFF;
    localparam logic [63:0] UNITY    = 64'h1_0000_0000;
    localparam logic [kctv_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } position_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic action;
    logic signed [31:0] meas_x;
    logic signed [31:0] meas_y;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic cfg_valid;
    logic cfg_ready;
    logic [kctv_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;

    // Predicted tracker state and registers
    logic [31:0] q_noise, r_noise, p_start;
    logic signed [31:0] trk_pos [2];
    logic signed [31:0] trk_vel [2];
    logic [63:0] trk_cov [2][3];

    position_t expected_positions [$];
    int errors;
    bit hold_off_rx;
    int hold_off_cycles;

    kalman_tracker_const_velocity_2d_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .meas_x(meas_x), .meas_y(meas_y),
        .out_valid(out_valid), .out_ready(out_ready),
        .est_x(est_x), .est_y(est_y),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard limit: ~500 updates plus stalls run well under a few ms
    initial
    begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    function automatic logic signed [31:0] clip32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [63:0] clip_cov(input logic [63:0] v);
        return (v > COV_SAT) ? COV_SAT : v;
    endfunction

    // floor(num * 2^32 / den), clamped to one, zero on a zero divisor
    function automatic logic [63:0] gain_of(input logic [63:0] num, input logic [63:0] den);
        logic [127:0] wide;
        if (den == 0)
            return '0;
        if (num >= den)
            return UNITY;
        wide = 128'({num, 32'd0});
        return 64'(wide / den);
    endfunction

    // round(a * k / 2^32) with the truncated low partial product of the block
    function automatic logic [63:0] scale_cov(input logic [63:0] a, input logic [63:0] k);
        logic [63:0] hi;
        if (k >= UNITY)
            return a;
        hi = a * (k >> 16) + ((a * (k & 64'hFFFF)) >> 16);
        return (hi + 64'h8000) >> 16;
    endfunction

    function automatic logic signed [31:0] nudge(input logic signed [31:0] base,
                                                 input logic signed [63:0] err,
                                                 input logic [63:0] k);
        logic [63:0] mag;
        logic [127:0] prod;
        logic signed [63:0] step;
        mag = err < 0 ? 64'(-err) : 64'(err);
        prod = 128'(mag) * 128'(k) + 128'h8000_0000;
        step = err < 0 ? -$signed(64'(prod >> 32)) : $signed(64'(prod >> 32));
        return clip32(64'(base) + step);
    endfunction

    function automatic logic signed [31:0] track_axis(input int ax,
                                                      input logic signed [31:0] z);
        logic [63:0] pp, pv, vv, s, k0, k1, t;
        logic signed [31:0] pred;
        logic signed [63:0] err;
        pred = clip32(64'(trk_pos[ax]) + 64'(trk_vel[ax]));
        err = 64'(z) - 64'(pred);
        pp = clip_cov(trk_cov[ax][0] + 2 * trk_cov[ax][1] + trk_cov[ax][2] + q_noise);
        pv = clip_cov(trk_cov[ax][1] + trk_cov[ax][2]);
        vv = clip_cov(trk_cov[ax][2] + q_noise);
        s = pp + r_noise;
        k0 = gain_of(pp, s);
        k1 = gain_of(pv, s);
        trk_pos[ax] = nudge(pred, err, k0);
        trk_vel[ax] = nudge(trk_vel[ax], err, k1);
        trk_cov[ax][0] = scale_cov(pp, UNITY - k0);
        trk_cov[ax][1] = scale_cov(pv, UNITY - k0);
        t = scale_cov(pv, k1);
        trk_cov[ax][2] = vv >= t ? vv - t : '0;
        return trk_pos[ax];
    endfunction

    function automatic position_t predict_estimate(input logic act,
                                                   input logic signed [31:0] zx,
                                                   input logic signed [31:0] zy);
        position_t r;
        if (act == kctv_pkg::ACT_START)
        begin
            trk_pos[0] = zx; trk_pos[1] = zy;
            for (int a = 0; a < 2; a++)
            begin
                trk_vel[a] = '0;
                trk_cov[a][0] = 64'(p_start);
                trk_cov[a][1] = '0;
                trk_cov[a][2] = 64'(p_start);
            end
            r.x = zx; r.y = zy;
        end
        else
        begin
            r.x = track_axis(0, zx);
            r.y = track_axis(1, zy);
        end
        return r;
    endfunction

    // Send one word; prediction taken at acceptance. The block is busy in the cycle after
    // acceptance, so drop valid for that cycle.
    task automatic send_word(input logic act, input logic signed [31:0] zx,
                             input logic signed [31:0] zy);
        in_valid <= 1'b1;
        action <= act;
        meas_x <= zx;
        meas_y <= zy;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_positions.push_back(predict_estimate(act, zx, zy));
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Bursty sender: send one word, then at random leave a gap with valid low
    task automatic send_bursty(input logic act, input logic signed [31:0] zx,
                               input logic signed [31:0] zy);
        send_word(act, zx, zy);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 20)) @(posedge clk);
    endtask

    task automatic drain;
        while (expected_positions.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [kctv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            kctv_pkg::CFG_PROCESS_NOISE:    q_noise = val;
            kctv_pkg::CFG_MEASURE_NOISE:    r_noise = val;
            kctv_pkg::CFG_START_COVARIANCE: p_start = val;
            default:                        ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [31:0] near(input logic signed [31:0] c);
        return clip32(64'(c) + $signed(64'($urandom_range(0, 32'h0004_0000))) - 64'sh2_0000);
    endfunction

    task automatic test_directed;
        send_word(kctv_pkg::ACT_UPDATE, 32'sh0001_0000, -32'sh0001_0000);
        send_word(kctv_pkg::ACT_START, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(kctv_pkg::ACT_UPDATE, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(kctv_pkg::ACT_UPDATE, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(kctv_pkg::ACT_START, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_word(kctv_pkg::ACT_UPDATE, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_word(kctv_pkg::ACT_UPDATE, 0, 0);
        send_word(kctv_pkg::ACT_START, 0, 0);
        send_word(kctv_pkg::ACT_UPDATE, 32'hFFFF_FFFF, 32'sh5555_5555);
        send_word(kctv_pkg::ACT_UPDATE, 32'shAAAA_AAAA, 32'sh0000_0001);
        drain();
    endtask

    // Zero innovation variance: no noise, no covariance, gains zero
    task automatic test_zero_variance;
        write_reg(kctv_pkg::CFG_PROCESS_NOISE, 0);
        write_reg(kctv_pkg::CFG_MEASURE_NOISE, 0);
        write_reg(kctv_pkg::CFG_START_COVARIANCE, 0);
        send_word(kctv_pkg::ACT_START, 32'sh0010_0000, -32'sh0010_0000);
        repeat (4) send_word(kctv_pkg::ACT_UPDATE, $urandom, $urandom);
        drain();
    endtask

    // Saturating covariances and the ignored register index
    task automatic test_extreme_regs;
        write_reg(kctv_pkg::CFG_PROCESS_NOISE, 32'hFFFF_FFFF);
        write_reg(kctv_pkg::CFG_MEASURE_NOISE, 32'hFFFF_FFFF);
        write_reg(kctv_pkg::CFG_START_COVARIANCE, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED, 32'h1234_5678);
        send_word(kctv_pkg::ACT_START, 0, 0);
        repeat (6) send_word(kctv_pkg::ACT_UPDATE, $urandom, $urandom);
        drain();
        write_reg(kctv_pkg::CFG_MEASURE_NOISE, 0);
        repeat (4) send_word(kctv_pkg::ACT_UPDATE, $urandom, $urandom);
        drain();
    endtask

    // Receiver holds off while the sender keeps offering words
    task automatic test_backpressure;
        hold_off_cycles = 600;
        hold_off_rx = 1'b1;
        for (int i = 0; i < 6; i++)
            send_word(i == 0 ? kctv_pkg::ACT_START : kctv_pkg::ACT_UPDATE, $urandom, $urandom);
        drain();
    endtask

    task automatic test_random_tracks(input int words);
        logic signed [31:0] cx, cy, vx, vy;
        int left;
        left = words;
        while (left > 0)
        begin
            case ($urandom_range(0, 3))
                0: write_reg(kctv_pkg::CFG_PROCESS_NOISE, $urandom_range(0, 3) == 0 ? $urandom
                                                           : $urandom_range(0, 20000));
                1: write_reg(kctv_pkg::CFG_MEASURE_NOISE, $urandom_range(0, 3) == 0 ? $urandom
                                                           : $urandom_range(0, 4000000));
                2: write_reg(kctv_pkg::CFG_START_COVARIANCE,
                             $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000000));
                default: ;
            endcase
            // Mostly a started track followed by noisy measurements on a line
            cx = $urandom; cy = $urandom;
            vx = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh4_0000;
            vy = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh4_0000;
            send_bursty(kctv_pkg::ACT_START, cx, cy);
            left--;
            repeat ($urandom_range(5, 30))
            begin
                cx = clip32(64'(cx) + 64'(vx));
                cy = clip32(64'(cy) + 64'(vy));
                if ($urandom_range(0, 9) == 0)
                    send_bursty(1'($urandom_range(0, 1)), $urandom, $urandom);
                else
                    send_bursty(kctv_pkg::ACT_UPDATE, near(cx), near(cy));
                left--;
            end
            drain();
        end
    endtask

    // Receiver stall pattern, with a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_rx)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_rx = 1'b0;
            end
            else if ($urandom_range(0, 63) < 8)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge clk)
    begin
        position_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_positions.size() == 0)
            begin
                $error("result word with none expected: %0d %0d", est_x, est_y);
                errors++;
            end
            else
            begin
                e = expected_positions.pop_front();
                if (est_x !== e.x)
                begin
                    $error("est_x expected %0d actual %0d", e.x, est_x);
                    errors++;
                end
                if (est_y !== e.y)
                begin
                    $error("est_y expected %0d actual %0d", e.y, est_y);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        hold_off_rx = 1'b0;
        hold_off_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = kctv_pkg::ACT_UPDATE;
        meas_x = 0;
        meas_y = 0;
        cfg_valid = 1'b0;
        cfg_index = kctv_pkg::CFG_PROCESS_NOISE;
        cfg_data = 0;
        q_noise = kctv_pkg::PROCESS_NOISE_RST;
        r_noise = kctv_pkg::MEASURE_NOISE_RST;
        p_start = kctv_pkg::START_COVARIANCE_RST;
        for (int a = 0; a < 2; a++)
        begin
            trk_pos[a] = '0;
            trk_vel[a] = '0;
            trk_cov[a][0] = 64'(kctv_pkg::START_COVARIANCE_RST);
            trk_cov[a][1] = '0;
            trk_cov[a][2] = 64'(kctv_pkg::START_COVARIANCE_RST);
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_zero_variance();
        test_extreme_regs();
        write_reg(kctv_pkg::CFG_PROCESS_NOISE, kctv_pkg::PROCESS_NOISE_RST);
        write_reg(kctv_pkg::CFG_MEASURE_NOISE, kctv_pkg::MEASURE_NOISE_RST);
        write_reg(kctv_pkg::CFG_START_COVARIANCE, kctv_pkg::START_COVARIANCE_RST);
        test_backpressure();
        test_random_tracks(420);

        drain();
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
